// ----- rtl/switch_ingress_admission_dispatch_assert.svh -----
// Assertion helpers for the RTL engine; clocked on i_clk, off while i_rst_n is low.
`ifndef SWITCH_INGRESS_ADMISSION_DISPATCH_ASSERT_SVH
`define SWITCH_INGRESS_ADMISSION_DISPATCH_ASSERT_SVH

// Same-cycle implication.
`define SIA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sia: assertion failed");

// Next-cycle implication.
`define SIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sia: assertion failed");

`endif

// ----- rtl/sia_pkg.sv -----
`timescale 1ns / 1ps
package sia_pkg;

    localparam int LEVEL_W    = 20;
    localparam int TIME_W     = 32;
    localparam int QUANTA_W   = 16;
    localparam int TICKS_W    = 16;
    localparam int CPUS_W     = 3;
    localparam int LEN_W      = 11;
    localparam int PROC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATERMARK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_QUANTA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CPUS_IN_USE    = 3'd5;

    typedef struct packed {
        logic [3:0]       port;
        logic [LEN_W-1:0] len;
        logic [7:0]       tag;
    } t_frame;

    typedef enum logic [0:0] {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_frame    frame;
    } t_cmd;

    typedef enum logic [2:0] {
        EV_START  = 3'd0,
        EV_QUEUED = 3'd1,
        EV_DROP   = 3'd2,
        EV_PAUSE  = 3'd3,
        EV_DONE   = 3'd4
    } t_event;

    typedef struct packed {
        t_event              kind;
        t_frame              frame;
        logic [PROC_W-1:0]   proc;
        logic [QUANTA_W-1:0] pause;
        logic [LEVEL_W-1:0]  level;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [LEVEL_W-1:0]  buffer_size;
        logic [LEVEL_W-1:0]  high_watermark;
        logic [QUANTA_W-1:0] pause_quanta;
        logic [TIME_W-1:0]   pause_interval;
        logic [TICKS_W-1:0]  proc_ticks;
        logic [CPUS_W-1:0]   cpus_in_use;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR_A,
        S_ARR_B,
        S_ARR_C,
        S_TK_INIT,
        S_TK_EVAL,
        S_TK_SETTLE
    } t_state;

endpackage

// ----- rtl/sia_in_if.sv -----
`timescale 1ns / 1ps
interface sia_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  frame_tag;
    logic [10:0] frame_length;
    logic [3:0]  arrival_port;

    modport source (output valid, opcode, frame_tag, frame_length, arrival_port,
                    input ready);
    modport sink   (input valid, opcode, frame_tag, frame_length, arrival_port,
                    output ready);
endinterface

// ----- rtl/sia_out_if.sv -----
`timescale 1ns / 1ps
interface sia_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  out_tag;
    logic [10:0] out_length;
    logic [3:0]  out_port;
    logic [1:0]  processor_index;
    logic [15:0] pause_value;
    logic [19:0] buffer_level;
    logic        last;

    modport source (output valid, event_kind, out_tag, out_length, out_port,
                    processor_index, pause_value, buffer_level, last,
                    input ready);
    modport sink   (input valid, event_kind, out_tag, out_length, out_port,
                    processor_index, pause_value, buffer_level, last,
                    output ready);
endinterface

// ----- rtl/switch_ingress_admission_dispatch.sv -----
// An arrival steps through S_ARR_A, S_ARR_B and S_ARR_C (S_ARR_C is skipped when refused
// for space); a tick through S_TK_INIT and one S_TK_EVAL per processor, plus S_TK_SETTLE
// after each queue pull by any processor but the last. Results leave through a register.
// Output stalls hold the engine; a two-entry command queue keeps the input open.
// Reset (i_rst_n low, synchronous) restores the register defaults and empties the
// queues and processors; the frame queue RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module switch_ingress_admission_dispatch
    import sia_pkg::*;
#(
    parameter int NUM_PROCESSORS = 4,
    parameter int QUEUE_DEPTH    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sia_in_if.sink                i_in,
    sia_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_size    <= LEVEL_W'(65536);
            r_cfg.high_watermark <= '0;
            r_cfg.pause_quanta   <= '0;
            r_cfg.pause_interval <= '0;
            r_cfg.proc_ticks     <= TICKS_W'(1);
            r_cfg.cpus_in_use    <= CPUS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUFFER_SIZE:    r_cfg.buffer_size    <= i_cfg_data[LEVEL_W-1:0];
                CFG_HIGH_WATERMARK: r_cfg.high_watermark <= i_cfg_data[LEVEL_W-1:0];
                CFG_PAUSE_QUANTA:   r_cfg.pause_quanta   <= i_cfg_data[QUANTA_W-1:0];
                CFG_PAUSE_INTERVAL: r_cfg.pause_interval <= i_cfg_data[TIME_W-1:0];
                CFG_PROC_TICKS:     r_cfg.proc_ticks     <= i_cfg_data[TICKS_W-1:0];
                CFG_CPUS_IN_USE:    r_cfg.cpus_in_use    <= i_cfg_data[CPUS_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    sia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    sia_engine #(
        .NUM_PROCESSORS (NUM_PROCESSORS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/sia_ram.sv -----
`timescale 1ns / 1ps
module sia_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sia_front.sv -----
`timescale 1ns / 1ps
module sia_front
    import sia_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sia_in_if.sink i_in,
    output t_cmd   o_cmd,
    output logic   o_cmd_valid,
    input  logic   i_cmd_pop
);

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       cmd_in;
    logic       push;
    logic       pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_cmd_pop && (r_cnt != 2'd0);

    // Classify the beat and pack the frame descriptor
    always_comb begin
        cmd_in.kind      = i_in.opcode ? CMD_TICK : CMD_ARRIVE;
        cmd_in.frame.tag  = i_in.frame_tag;
        cmd_in.frame.len  = i_in.frame_length;
        cmd_in.frame.port = i_in.arrival_port;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_cmd       = r_slot[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);

endmodule

// ----- rtl/sia_engine.sv -----
`timescale 1ns / 1ps
module sia_engine
    import sia_pkg::*;
#(
    parameter int NUM_PROCESSORS = 4,
    parameter int QUEUE_DEPTH    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    sia_out_if.source  o_out
);

    `include "switch_ingress_admission_dispatch_assert.svh"

    localparam int PIW = (NUM_PROCESSORS > 1) ? $clog2(NUM_PROCESSORS) : 1;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_state              r_state, n_state;
    logic [LEVEL_W-1:0]  r_bytes, n_bytes;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [TIME_W-1:0]   r_last_pause, n_last_pause;
    logic                r_busy [NUM_PROCESSORS];
    logic                n_busy [NUM_PROCESSORS];
    logic [TICKS_W-1:0]  r_count [NUM_PROCESSORS];
    logic [TICKS_W-1:0]  n_count [NUM_PROCESSORS];
    t_frame              r_pframe [NUM_PROCESSORS];
    t_frame              n_pframe [NUM_PROCESSORS];
    logic                r_exp [NUM_PROCESSORS];
    logic                n_exp [NUM_PROCESSORS];
    logic [QAW-1:0]      r_head, n_head;
    logic [QCW-1:0]      r_pcnt, n_pcnt;
    logic [PIW-1:0]      r_idx, n_idx;
    t_frame              r_cur, n_cur;
    logic                r_admit, n_admit;
    logic [LEVEL_W-1:0]  r_sum, n_sum;
    logic [TIME_W-1:0]   r_dt, n_dt;
    logic                r_found, n_found;
    logic [PIW-1:0]      r_free_idx, n_free_idx;
    logic                r_out_valid;
    t_result             r_out;

    logic                step;
    logic                emit;
    logic                load;
    logic                pull;
    logic                out_free;
    logic                last_idx;
    logic                later;
    logic                pause_hit;
    t_result             res;
    logic                ram_we;
    logic [QAW-1:0]      ram_waddr;
    logic [QAW:0]        wsum;
    logic [$bits(t_frame)-1:0] ram_rdata;
    logic [TICKS_W-1:0]  start_ticks;
    logic [LEVEL_W:0]    sum_wide;
    logic [LEVEL_W-1:0]  rel_level;
    logic [LEVEL_W-1:0]  cur_len;
    logic [LEVEL_W-1:0]  proc_len;

    assign out_free    = !r_out_valid || o_out.ready;
    assign load        = emit && out_free;
    assign last_idx    = (r_idx == PIW'(NUM_PROCESSORS - 1));
    assign start_ticks = (i_cfg.proc_ticks == '0) ? TICKS_W'(1) : i_cfg.proc_ticks;
    assign cur_len     = LEVEL_W'(r_cur.len);
    assign proc_len    = LEVEL_W'(r_pframe[r_idx].len);
    assign sum_wide    = {1'b0, r_bytes} + {1'b0, cur_len};
    assign rel_level   = (r_bytes >= proc_len) ? (r_bytes - proc_len) : '0;
    assign pause_hit   = (i_cfg.pause_quanta != '0) && (i_cfg.high_watermark != '0) &&
                         (r_sum >= i_cfg.high_watermark) && (r_dt > i_cfg.pause_interval);
    assign wsum        = (QAW+1)'(r_head) + (QAW+1)'(r_pcnt);
    assign ram_waddr   = (wsum >= (QAW+1)'(QUEUE_DEPTH)) ?
                         QAW'(wsum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(wsum);

    sia_ram #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cur),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Expiring processors above the current one decide the last flag
    always_comb begin
        later = 1'b0;
        for (int j = 0; j < NUM_PROCESSORS; j++) begin
            if (r_exp[j] && (32'(j) > 32'(r_idx))) begin
                later = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (step) begin
                    n_state = (i_cmd.kind == CMD_TICK) ? S_TK_INIT : S_ARR_A;
                end
            end
            S_ARR_A:     n_state = S_ARR_B;
            S_ARR_B: begin
                if (step) begin
                    n_state = r_admit ? S_ARR_C : S_IDLE;
                end
            end
            S_ARR_C: begin
                if (step) begin
                    n_state = S_IDLE;
                end
            end
            S_TK_INIT:   n_state = S_TK_EVAL;
            S_TK_EVAL: begin
                if (step) begin
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else if (pull) begin
                        n_state = S_TK_SETTLE;
                    end else begin
                        n_state = S_TK_EVAL;
                    end
                end
            end
            S_TK_SETTLE: n_state = S_TK_EVAL;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        step         = 1'b0;
        emit         = 1'b0;
        pull         = 1'b0;
        ram_we       = 1'b0;
        o_cmd_pop    = 1'b0;
        res          = '0;
        res.kind     = EV_DROP;
        n_bytes      = r_bytes;
        n_time       = r_time;
        n_last_pause = r_last_pause;
        n_busy       = r_busy;
        n_count      = r_count;
        n_pframe     = r_pframe;
        n_exp        = r_exp;
        n_head       = r_head;
        n_pcnt       = r_pcnt;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_admit      = r_admit;
        n_sum        = r_sum;
        n_dt         = r_dt;
        n_found      = r_found;
        n_free_idx   = r_free_idx;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_cmd.frame;
                    step      = 1'b1;
                end
            end
            S_ARR_A: begin
                n_admit = (sum_wide < {1'b0, i_cfg.buffer_size});
                n_sum   = sum_wide[LEVEL_W-1:0];
                n_dt    = r_time - r_last_pause;
                n_found = 1'b0;
                // Descend so the lowest idle enabled processor wins
                for (int i = NUM_PROCESSORS - 1; i >= 0; i--) begin
                    if (!r_busy[i] && (32'(i) < 32'(i_cfg.cpus_in_use))) begin
                        n_found    = 1'b1;
                        n_free_idx = PIW'(i);
                    end
                end
                step = 1'b1;
            end
            S_ARR_B: begin
                res.frame = r_cur;
                if (!r_admit) begin
                    emit      = 1'b1;
                    res.kind  = EV_DROP;
                    res.level = r_bytes;
                    res.last  = 1'b1;
                    step      = out_free;
                end else begin
                    if (pause_hit) begin
                        emit      = 1'b1;
                        res.kind  = EV_PAUSE;
                        res.pause = i_cfg.pause_quanta;
                        res.level = r_sum;
                        step      = out_free;
                    end else begin
                        step = 1'b1;
                    end
                    if (step) begin
                        n_bytes = r_sum;
                        if (pause_hit) begin
                            n_last_pause = r_time;
                        end
                    end
                end
            end
            S_ARR_C: begin
                emit      = 1'b1;
                step      = out_free;
                res.frame = r_cur;
                res.last  = 1'b1;
                res.level = r_bytes;
                if (r_found) begin
                    res.kind = EV_START;
                    res.proc = PROC_W'(r_free_idx);
                    if (step) begin
                        n_busy[r_free_idx]   = 1'b1;
                        n_count[r_free_idx]  = start_ticks;
                        n_pframe[r_free_idx] = r_cur;
                    end
                end else if (r_pcnt < QCW'(QUEUE_DEPTH)) begin
                    res.kind = EV_QUEUED;
                    if (step) begin
                        ram_we = 1'b1;
                        n_pcnt = r_pcnt + 1'b1;
                    end
                end else begin
                    // Queue full: give the bytes back
                    res.kind  = EV_DROP;
                    res.level = r_bytes - cur_len;
                    if (step) begin
                        n_bytes = r_bytes - cur_len;
                    end
                end
            end
            S_TK_INIT: begin
                n_time = r_time + 1'b1;
                for (int i = 0; i < NUM_PROCESSORS; i++) begin
                    n_exp[i] = r_busy[i] && (r_count[i] <= TICKS_W'(1));
                end
                n_idx = '0;
                step  = 1'b1;
            end
            S_TK_EVAL: begin
                step = 1'b1;
                if (r_busy[r_idx]) begin
                    if (r_exp[r_idx]) begin
                        emit      = 1'b1;
                        step      = out_free;
                        res.kind  = EV_DONE;
                        res.frame = r_pframe[r_idx];
                        res.proc  = PROC_W'(r_idx);
                        res.level = rel_level;
                        res.last  = !later;
                        if (step) begin
                            n_bytes = rel_level;
                            if (r_pcnt != '0) begin
                                pull            = 1'b1;
                                n_pframe[r_idx] = t_frame'(ram_rdata);
                                n_count[r_idx]  = start_ticks;
                                n_pcnt          = r_pcnt - 1'b1;
                                n_head          = (r_head == QAW'(QUEUE_DEPTH - 1)) ?
                                                  '0 : r_head + 1'b1;
                            end else begin
                                n_busy[r_idx] = 1'b0;
                            end
                        end
                    end else begin
                        n_count[r_idx] = r_count[r_idx] - 1'b1;
                    end
                end
                if (step && !last_idx) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TK_SETTLE: begin
                // Wait for the new queue head to come out of the RAM
                step = 1'b1;
            end
            default: begin
                step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bytes      <= '0;
            r_time       <= '0;
            r_last_pause <= '0;
            r_head       <= '0;
            r_pcnt       <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_PROCESSORS; i++) begin
                r_busy[i]  <= 1'b0;
                r_count[i] <= '0;
                r_exp[i]   <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_bytes      <= n_bytes;
            r_time       <= n_time;
            r_last_pause <= n_last_pause;
            r_head       <= n_head;
            r_pcnt       <= n_pcnt;
            r_idx        <= n_idx;
            r_busy       <= n_busy;
            r_count      <= n_count;
            r_exp        <= n_exp;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pframe   <= n_pframe;
        r_cur      <= n_cur;
        r_admit    <= n_admit;
        r_sum      <= n_sum;
        r_dt       <= n_dt;
        r_found    <= n_found;
        r_free_idx <= n_free_idx;
        if (load) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.event_kind      = r_out.kind;
    assign o_out.out_tag         = r_out.frame.tag;
    assign o_out.out_length      = r_out.frame.len;
    assign o_out.out_port        = r_out.frame.port;
    assign o_out.processor_index = r_out.proc;
    assign o_out.pause_value     = r_out.pause;
    assign o_out.buffer_level    = r_out.level;
    assign o_out.last            = r_out.last;

    `SIA_ASSERT_NOW(a_queue_write_room, ram_we, r_pcnt < QCW'(QUEUE_DEPTH))
    `SIA_ASSERT_NEXT(a_pull_settles, pull, r_state == S_TK_SETTLE || r_state == S_IDLE)
    `SIA_ASSERT_NOW(a_busy_has_count, r_state == S_TK_EVAL && r_busy[r_idx],
                    r_count[r_idx] != '0)
    `SIA_ASSERT_NEXT(a_arrival_ends, load && r_state == S_ARR_C, r_state == S_IDLE)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import sia_pkg::*;

    localparam int NPROC  = 4;
    localparam int QDEPTH = 64;
    localparam int SETTLE = 40;

    class admission_scoreboard;
        t_cfg               regs;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  now_ticks;
        logic [TIME_W-1:0]  last_pause;
        bit                 busy[NPROC];
        logic [TICKS_W-1:0] countdown[NPROC];
        t_frame             on_proc[NPROC];
        t_frame             backlog[$];
        t_result            expected[$];
        int unsigned        mismatches;
        int unsigned        kind_seen[5];

        function new();
            regs.buffer_size    = 20'h10000;
            regs.high_watermark = '0;
            regs.pause_quanta   = '0;
            regs.pause_interval = '0;
            regs.proc_ticks     = 16'd1;
            regs.cpus_in_use    = 3'd1;
            level      = '0;
            now_ticks  = '0;
            last_pause = '0;
            for (int p = 0; p < NPROC; p++) begin
                busy[p]      = 1'b0;
                countdown[p] = '0;
            end
            mismatches = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BUFFER_SIZE:    regs.buffer_size    = data[LEVEL_W-1:0];
                CFG_HIGH_WATERMARK: regs.high_watermark = data[LEVEL_W-1:0];
                CFG_PAUSE_QUANTA:   regs.pause_quanta   = data[QUANTA_W-1:0];
                CFG_PAUSE_INTERVAL: regs.pause_interval = data[TIME_W-1:0];
                CFG_PROC_TICKS:     regs.proc_ticks     = data[TICKS_W-1:0];
                CFG_CPUS_IN_USE:    regs.cpus_in_use    = data[CPUS_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero processing ticks behaves as one
        function logic [TICKS_W-1:0] run_ticks();
            return (regs.proc_ticks == 0) ? 16'd1 : regs.proc_ticks;
        endfunction

        function void push(t_event k, t_frame f, int proc, logic [QUANTA_W-1:0] pv);
            t_result r;
            r.kind  = k;
            r.frame = f;
            r.proc  = proc[PROC_W-1:0];
            r.pause = pv;
            r.level = level;
            r.last  = 1'b0;
            expected.push_back(r);
        endfunction

        function void note_input(t_cmd c);
            int          made_before;
            int          slots;
            int          p;
            int unsigned sum;
            made_before = expected.size();
            if (c.kind == CMD_ARRIVE) begin
                sum = level + c.frame.len;
                if (sum < regs.buffer_size) begin
                    level = sum[LEVEL_W-1:0];
                    if (regs.pause_quanta != 0 && regs.high_watermark != 0 &&
                        level >= regs.high_watermark &&
                        (now_ticks - last_pause) > regs.pause_interval) begin
                        push(EV_PAUSE, c.frame, 0, regs.pause_quanta);
                        last_pause = now_ticks;
                    end
                    slots = (regs.cpus_in_use > NPROC) ? NPROC : regs.cpus_in_use;
                    p = 0;
                    while (p < slots && busy[p]) p++;
                    if (p < slots) begin
                        busy[p]      = 1'b1;
                        countdown[p] = run_ticks();
                        on_proc[p]   = c.frame;
                        push(EV_START, c.frame, p, '0);
                    end else if (backlog.size() < QDEPTH) begin
                        backlog.push_back(c.frame);
                        push(EV_QUEUED, c.frame, 0, '0);
                    end else begin
                        // queue full: give the bytes back
                        level = level - c.frame.len;
                        push(EV_DROP, c.frame, 0, '0);
                    end
                end else begin
                    push(EV_DROP, c.frame, 0, '0);
                end
            end else begin
                now_ticks = now_ticks + 1;
                for (int q = 0; q < NPROC; q++) begin
                    if (busy[q]) begin
                        if (countdown[q] != 0) countdown[q] = countdown[q] - 1;
                        if (countdown[q] == 0) begin
                            level = (level >= on_proc[q].len) ? level - on_proc[q].len : '0;
                            push(EV_DONE, on_proc[q], q, '0);
                            // a finished processor pulls the queue head, enabled or not
                            if (backlog.size() > 0) begin
                                on_proc[q]   = backlog.pop_front();
                                countdown[q] = run_ticks();
                            end else begin
                                busy[q] = 1'b0;
                            end
                        end
                    end
                end
            end
            if (expected.size() > made_before) expected[$].last = 1'b1;
        endfunction

        function void field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check(t_result got);
            t_result want;
            if (expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual kind %0d tag %0h",
                         $time, got.kind, got.frame.tag);
                return;
            end
            want = expected.pop_front();
            if (int'(got.kind) < 5) kind_seen[int'(got.kind)]++;
            field("event_kind", want.kind, got.kind);
            field("out_tag", want.frame.tag, got.frame.tag);
            field("out_length", want.frame.len, got.frame.len);
            field("out_port", want.frame.port, got.frame.port);
            field("processor_index", want.proc, got.proc);
            field("pause_value", want.pause, got.pause);
            field("buffer_level", want.level, got.level);
            field("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sia_in_if  in_bus ();
    sia_out_if out_bus ();

    admission_scoreboard board;
    int unsigned         beats_in;

    switch_ingress_admission_dispatch #(
        .NUM_PROCESSORS (NPROC),
        .QUEUE_DEPTH    (QDEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // Receiver: runs of full speed, random stalls and long stalls
    initial begin
        int mode;
        int span;
        out_bus.ready = 1'b0;
        forever begin
            mode = $urandom_range(2);
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: out_bus.ready = 1'b1;
                    1: out_bus.ready = $urandom_range(1);
                    default: out_bus.ready = ($urandom_range(7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.kind       = t_event'(out_bus.event_kind);
            got.frame.tag  = out_bus.out_tag;
            got.frame.len  = out_bus.out_length;
            got.frame.port = out_bus.out_port;
            got.proc       = out_bus.processor_index;
            got.pause      = out_bus.pause_value;
            got.level      = out_bus.buffer_level;
            got.last       = out_bus.last;
            board.check(got);
        end
    end

    task automatic send(input t_cmd c);
        @(negedge i_clk);
        in_bus.valid        = 1'b1;
        in_bus.opcode       = c.kind;
        in_bus.frame_tag    = c.frame.tag;
        in_bus.frame_length = c.frame.len;
        in_bus.arrival_port = c.frame.port;
        do @(posedge i_clk); while (!in_bus.ready);
        board.note_input(c);
        beats_in++;
    endtask

    task automatic send_arrival(input logic [7:0] tag, input logic [LEN_W-1:0] len,
                                input logic [3:0] port);
        t_cmd c;
        c.kind       = CMD_ARRIVE;
        c.frame.tag  = tag;
        c.frame.len  = len;
        c.frame.port = port;
        send(c);
    endtask

    task automatic send_tick();
        t_cmd c;
        c.kind  = CMD_TICK;
        c.frame = t_frame'($bits(t_frame)'($urandom));
        send(c);
    endtask

    task automatic gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_bus.valid = 1'b0;
        end
    endtask

    task automatic hold_until_drained();
        gap(1);
        while (board.expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Wait for the engine to go quiet, then load every register
    task automatic apply_settings(input logic [31:0] bsize, input logic [31:0] wmark,
                                  input logic [31:0] quanta, input logic [31:0] interval,
                                  input logic [31:0] pticks, input logic [31:0] cpus);
        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        cfg_write(CFG_BUFFER_SIZE, bsize);
        cfg_write(CFG_HIGH_WATERMARK, wmark);
        cfg_write(CFG_PAUSE_QUANTA, quanta);
        cfg_write(CFG_PAUSE_INTERVAL, interval);
        cfg_write(CFG_PROC_TICKS, pticks);
        cfg_write(CFG_CPUS_IN_USE, cpus);
    endtask

    function automatic logic [LEN_W-1:0] pick_len(input int len_max);
        case ($urandom_range(9))
            0: return '0;
            1: return 11'd2047;
            default: return LEN_W'($urandom_range(len_max));
        endcase
    endfunction

    // Bursts of random length; optional gaps and the odd hold for a full drain
    task automatic run_random(input int count, input int tick_pct, input int len_max,
                              input bit gaps);
        int   burst;
        t_cmd c;
        while (count > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && count > 0) begin
                c.kind       = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_ARRIVE;
                c.frame.tag  = 8'($urandom);
                c.frame.port = 4'($urandom);
                c.frame.len  = pick_len(len_max);
                send(c);
                burst--;
                count--;
            end
            if (gaps) begin
                if ($urandom_range(15) == 0) hold_until_drained();
                gap($urandom_range(0, 5));
            end
        end
    endtask

    initial begin
        board      = new();
        beats_in   = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_bus.valid        = 1'b0;
        in_bus.opcode       = CMD_ARRIVE;
        in_bus.frame_tag    = '0;
        in_bus.frame_length = '0;
        in_bus.arrival_port = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults: field extremes, start, queue, completions, empty tick
        send_arrival(8'h00, 11'd0, 4'h0);
        send_arrival(8'hFF, 11'd2047, 4'hF);
        send_tick();
        send_tick();
        send_tick();

        // Zero buffer admits nothing
        apply_settings(32'h0, 32'hFFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_arrival(8'hA5, 11'd0, 4'h5);

        // No processors enabled: frames queue; pause needs a tick since the last one
        apply_settings(32'hFFFFF, 32'h1, 32'hFFFF, 32'h0, 32'h0, 32'h0);
        send_arrival(8'h5A, 11'd100, 4'h3);
        send_tick();
        send_arrival(8'h3C, 11'd200, 4'hC);
        send_arrival(8'hC3, 11'd1024, 4'h9);

        // Processor count above the limit saturates: all four take a frame
        apply_settings(32'hFFFFF, 32'h1, 32'hFFFF, 32'h2, 32'h3, 32'h7);
        repeat (4) send_arrival(8'($urandom), 11'd64, 4'($urandom));

        // Lower the count while processors are busy; they finish and keep pulling
        apply_settings(32'hFFFFF, 32'h1, 32'hFFFF, 32'h2, 32'h3, 32'h1);
        repeat (3) send_tick();
        send_arrival(8'h22, 11'd333, 4'h2);
        repeat (3) send_tick();

        apply_settings(32'd4096, 32'd2000, $urandom_range(1, 65535), 32'h0, 32'h2, 32'h2);
        run_random(8, 45, 1500, 1'b1);
        hold_until_drained();

        apply_settings($urandom_range(20000, 1048575), 32'd10000, $urandom_range(1, 65535),
                       32'h1, 32'h0, 32'h3);
        run_random(8, 40, 2047, 1'b1);

        apply_settings(32'hFFFFF, 32'hFFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'h5, 32'h4);
        run_random(8, 35, 2047, 1'b0);

        // Longest processing time: fill every processor and the whole queue, overflow it
        apply_settings(32'hFFFFF, 32'd60000, 32'h1234, 32'h0, 32'hFFFF, 32'h7);
        run_random(69, 0, 2047, 1'b0);

        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("summary: %0d beats in; start %0d, queued %0d, drop %0d, pause %0d, done %0d",
                 beats_in, board.kind_seen[EV_START], board.kind_seen[EV_QUEUED],
                 board.kind_seen[EV_DROP], board.kind_seen[EV_PAUSE], board.kind_seen[EV_DONE]);
        $display("summary: zero and full buffer, pause spacing, queue overflow, 0..7 processors");
        if (board.mismatches == 0 && board.expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sia_pkg.sv
rtl/sia_in_if.sv
rtl/sia_out_if.sv
rtl/sia_ram.sv
rtl/sia_front.sv
rtl/sia_engine.sv
rtl/switch_ingress_admission_dispatch.sv
dv/tb.sv
